>>> design/gkac_pkg.sv
// Shared constants, types and width helpers for the gap-keeping acceleration command block.
package gkac_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int SLOT_W         = 16;
  localparam int PCT_W          = 7;
  localparam int APB_DW         = 64;
  localparam int APB_AW         = 6;
  localparam int REG_SEL_LSB    = 3;
  localparam int PIPE_DEPTH     = 8;
  localparam int CORR_W         = 32;
  localparam int PCT_SCALE      = 100;
  localparam int RND_SH         = 13;
  localparam int RND_HALF       = 4096;

  typedef enum logic [2:0] {
    REG_SPEED_THR   = 3'd0,
    REG_GAP         = 3'd1,
    REG_GAINS_LO    = 3'd2,
    REG_GAINS_MID   = 3'd3,
    REG_GAINS_HI    = 3'd4,
    REG_ACCEL_LIM   = 3'd5,
    REG_PEDAL_LIM   = 3'd6,
    REG_PEDAL_SLOPE = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    STAGE_LOW  = 2'd0,
    STAGE_MID  = 2'd1,
    STAGE_HIGH = 2'd2
  } speed_stage_t;

  typedef struct packed {
    logic [31:0] speed_thresholds;
    logic [47:0] gap_settings;
    logic [47:0] gains_low_speed;
    logic [47:0] gains_mid_speed;
    logic [47:0] gains_high_speed;
    logic [31:0] accel_limits;
    logic [47:0] pedal_limits;
    logic [63:0] pedal_slopes;
  } cfg_regs_t;

  function automatic int op_w(input int dw);
    return ((dw > SLOT_W) ? dw : SLOT_W) + 1;
  endfunction

  function automatic int acc_w(input int dw);
    return op_w(dw) + SLOT_W + 6;
  endfunction

  function automatic int cmd_w(input int dw);
    return acc_w(dw) - RND_SH;
  endfunction

endpackage

>>> design/gkac_ifs.sv
// Valid/ready channel interfaces for the sample input and the command output.
interface gkac_in_if #(
  parameter int DATA_WIDTH = gkac_pkg::DATA_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [DATA_WIDTH-1:0]  leader_speed;
  logic signed [DATA_WIDTH-1:0]  own_speed;
  logic signed [DATA_WIDTH-1:0]  leader_accel;
  logic [DATA_WIDTH-2:0]         gap_distance;
  logic [gkac_pkg::PCT_W-1:0]    brake_pedal_pct;
  logic [gkac_pkg::PCT_W-1:0]    throttle_pedal_pct;

  modport source (
    output valid, leader_speed, own_speed, leader_accel, gap_distance,
           brake_pedal_pct, throttle_pedal_pct,
    input  ready
  );
  modport sink (
    input  valid, leader_speed, own_speed, leader_accel, gap_distance,
           brake_pedal_pct, throttle_pedal_pct,
    output ready
  );
endinterface

interface gkac_out_if #(
  parameter int DATA_WIDTH = gkac_pkg::DATA_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [DATA_WIDTH-1:0]  accel_command;
  logic                          limited;
  logic [1:0]                    speed_stage;

  modport source (
    output valid, accel_command, limited, speed_stage,
    input  ready
  );
  modport sink (
    input  valid, accel_command, limited, speed_stage,
    output ready
  );
endinterface

>>> design/gkac_cfg_regs.sv
// APB register file holding the gain, gap, limit and pedal settings.
module gkac_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gkac_pkg::APB_AW-1:0]       paddr,
  input  logic [gkac_pkg::APB_DW-1:0]       pwdata,
  output logic [gkac_pkg::APB_DW-1:0]       prdata,
  output logic                              pready,
  output gkac_pkg::cfg_regs_t               cfg
);

  gkac_pkg::cfg_regs_t cfg_r;
  gkac_pkg::cfg_regs_t cfg_nxt;
  gkac_pkg::reg_idx_t  sel;
  logic                wr_en;

  assign sel    = gkac_pkg::reg_idx_t'(paddr[gkac_pkg::APB_AW-1:gkac_pkg::REG_SEL_LSB]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (sel)
        gkac_pkg::REG_SPEED_THR:   cfg_nxt.speed_thresholds = pwdata[31:0];
        gkac_pkg::REG_GAP:         cfg_nxt.gap_settings     = pwdata[47:0];
        gkac_pkg::REG_GAINS_LO:    cfg_nxt.gains_low_speed  = pwdata[47:0];
        gkac_pkg::REG_GAINS_MID:   cfg_nxt.gains_mid_speed  = pwdata[47:0];
        gkac_pkg::REG_GAINS_HI:    cfg_nxt.gains_high_speed = pwdata[47:0];
        gkac_pkg::REG_ACCEL_LIM:   cfg_nxt.accel_limits     = pwdata[31:0];
        gkac_pkg::REG_PEDAL_LIM:   cfg_nxt.pedal_limits     = pwdata[47:0];
        gkac_pkg::REG_PEDAL_SLOPE: cfg_nxt.pedal_slopes     = pwdata[63:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      gkac_pkg::REG_SPEED_THR:   prdata = gkac_pkg::APB_DW'(cfg_r.speed_thresholds);
      gkac_pkg::REG_GAP:         prdata = gkac_pkg::APB_DW'(cfg_r.gap_settings);
      gkac_pkg::REG_GAINS_LO:    prdata = gkac_pkg::APB_DW'(cfg_r.gains_low_speed);
      gkac_pkg::REG_GAINS_MID:   prdata = gkac_pkg::APB_DW'(cfg_r.gains_mid_speed);
      gkac_pkg::REG_GAINS_HI:    prdata = gkac_pkg::APB_DW'(cfg_r.gains_high_speed);
      gkac_pkg::REG_ACCEL_LIM:   prdata = gkac_pkg::APB_DW'(cfg_r.accel_limits);
      gkac_pkg::REG_PEDAL_LIM:   prdata = gkac_pkg::APB_DW'(cfg_r.pedal_limits);
      gkac_pkg::REG_PEDAL_SLOPE: prdata = cfg_r.pedal_slopes;
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> design/gkac_law.sv
// Gain stage select, distance-error law products and law sum, delayed to the merge stage.
module gkac_law #(
  parameter int DATA_WIDTH = gkac_pkg::DATA_WIDTH_DEF
) (
  input  logic                                        clk,
  input  logic [gkac_pkg::PIPE_DEPTH-1:0]             stage_en,
  input  gkac_pkg::cfg_regs_t                         cfg,
  input  logic signed [DATA_WIDTH-1:0]                leader_speed,
  input  logic signed [DATA_WIDTH-1:0]                own_speed,
  input  logic signed [DATA_WIDTH-1:0]                leader_accel,
  input  logic [DATA_WIDTH-2:0]                       gap_distance,
  output logic signed [gkac_pkg::acc_w(DATA_WIDTH)-1:0] law_acc,
  output logic [1:0]                                  speed_stage
);

  localparam int OPW    = gkac_pkg::op_w(DATA_WIDTH);
  localparam int PW     = OPW + gkac_pkg::SLOT_W;
  localparam int AW     = gkac_pkg::acc_w(DATA_WIDTH);
  localparam int SW     = gkac_pkg::SLOT_W;
  localparam int ST_LEN = 6;
  localparam int AC_LEN = 4;

  typedef logic signed [SW-1:0] slot_t;

  // stage 1 decode
  gkac_pkg::speed_stage_t stage_sel;
  logic [47:0]            gains;
  logic signed [OPW-1:0]  v2_x, thr0_x, thr1_x, e_x, dv_x;
  slot_t                  lo_s, hi_s, lo_o, hi_o;
  logic                   inside_nxt;

  slot_t                  ka_r, kv_r, kd_r;
  logic signed [OPW-1:0]  a1_r, dv_r, e_r;
  logic                   inside1_r, inside2_r;

  logic signed [PW-1:0]   pa_nxt, pv_nxt, pd_nxt;
  logic signed [PW-1:0]   pa_r, pv_r, pd_r;

  logic signed [AW-1:0]   sum_in, sum_out, acc_pre, acc_nxt;
  logic signed [AW-1:0]   acc_r [AC_LEN];
  logic [1:0]             st_r  [ST_LEN];

  always_comb begin
    v2_x   = OPW'(own_speed);
    thr0_x = signed'(OPW'(cfg.speed_thresholds[15:0]));
    thr1_x = signed'(OPW'(cfg.speed_thresholds[31:16]));
    if (v2_x <= thr0_x) begin
      stage_sel = gkac_pkg::STAGE_LOW;
    end else if (v2_x <= thr1_x) begin
      stage_sel = gkac_pkg::STAGE_MID;
    end else begin
      stage_sel = gkac_pkg::STAGE_HIGH;
    end
    unique case (stage_sel)
      gkac_pkg::STAGE_LOW:  gains = cfg.gains_low_speed;
      gkac_pkg::STAGE_MID:  gains = cfg.gains_mid_speed;
      gkac_pkg::STAGE_HIGH: gains = cfg.gains_high_speed;
      default:              gains = cfg.gains_high_speed;
    endcase
    lo_s = slot_t'(cfg.gap_settings[31:16]);
    hi_s = slot_t'(cfg.gap_settings[47:32]);
    // swap a reversed dead band
    if (lo_s >= hi_s) begin
      lo_o = hi_s;
      hi_o = lo_s;
    end else begin
      lo_o = lo_s;
      hi_o = hi_s;
    end
    e_x  = signed'(OPW'(gap_distance)) - OPW'(slot_t'(cfg.gap_settings[15:0]));
    dv_x = OPW'(leader_speed) - OPW'(own_speed);
    inside_nxt = (e_x < OPW'(hi_o)) && (e_x > OPW'(lo_o));
  end

  assign pa_nxt = PW'(ka_r) * PW'(a1_r);
  assign pv_nxt = PW'(kv_r) * PW'(dv_r);
  assign pd_nxt = PW'(kd_r) * PW'(e_r);

  always_comb begin
    sum_in  = AW'(pa_r) + AW'(pv_r) + AW'(pd_r);
    sum_out = AW'(pa_r) + AW'(pv_r) + (AW'(pd_r) <<< 2);
    acc_pre = inside2_r ? (sum_in <<< 1) : sum_out;
    acc_nxt = (acc_pre < 0) ? (acc_pre <<< 2) : acc_pre;
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      ka_r      <= slot_t'(gains[15:0]);
      kv_r      <= slot_t'(gains[31:16]);
      kd_r      <= slot_t'(gains[47:32]);
      a1_r      <= OPW'(leader_accel);
      dv_r      <= dv_x;
      e_r       <= e_x;
      inside1_r <= inside_nxt;
      st_r[0]   <= stage_sel;
    end
    if (stage_en[1]) begin
      pa_r      <= pa_nxt;
      pv_r      <= pv_nxt;
      pd_r      <= pd_nxt;
      inside2_r <= inside1_r;
    end
    if (stage_en[2]) begin
      acc_r[0] <= acc_nxt;
    end
    for (int k = 1; k < AC_LEN; k++) begin
      if (stage_en[k+2]) begin
        acc_r[k] <= acc_r[k-1];
      end
    end
    for (int k = 1; k < ST_LEN; k++) begin
      if (stage_en[k]) begin
        st_r[k] <= st_r[k-1];
      end
    end
  end

  assign law_acc     = acc_r[AC_LEN-1];
  assign speed_stage = st_r[ST_LEN-1];

endmodule

>>> design/gkac_corr.sv
// Pedal correction pipeline: clamped slope term times pedal fraction, divided via reciprocal multiplies.
module gkac_corr (
  input  logic                                   clk,
  input  logic [gkac_pkg::PIPE_DEPTH-1:0]        stage_en,
  input  gkac_pkg::cfg_regs_t                    cfg,
  input  logic [gkac_pkg::PCT_W-1:0]             brake_pedal_pct,
  input  logic [gkac_pkg::PCT_W-1:0]             throttle_pedal_pct,
  output logic signed [gkac_pkg::CORR_W-1:0]     corr
);

  localparam int PW_      = gkac_pkg::PCT_W;
  localparam int CW       = gkac_pkg::CORR_W;
  localparam int TW       = 24;
  localparam int KW       = 28;
  localparam int NW       = 27;
  localparam int DIV_C    = 625;
  localparam int CAP_SCALE = 1600;
  localparam int K_BIAS   = DIV_C * (2 ** 17);
  localparam int QK_BIAS  = 2 ** 17;
  localparam int RECIP1   = (2 ** NW) / DIV_C;
  localparam int R1W      = 18;
  localparam int R1_SH    = NW;
  localparam int QW       = NW + R1W - R1_SH;
  localparam int QKW      = QW + 1;
  localparam int RW       = 11;
  localparam int RKW      = 10;
  localparam int MW       = 22;
  localparam int M_BIAS   = 312;
  localparam int SCALE_SH = 5;
  localparam int RECIP2   = (2 ** MW) / DIV_C;
  localparam int R2W      = 13;
  localparam int R2_SH    = MW;
  localparam int Q2W      = MW + R2W - R2_SH;

  typedef logic signed [gkac_pkg::SLOT_W-1:0] slot_t;

  // stage 1
  logic                  brake_on;
  logic [PW_-1:0]        pct;
  slot_t                 eff, slope, offset, maxv;
  logic signed [TW-1:0]  pct_sc, eff_sc;
  logic signed [KW-1:0]  k_raw, k_cap, k_sel, k_bias;
  logic [NW-1:0]         n1_nxt;
  logic                  on1_nxt;

  logic [NW-1:0]         n1_r, n2_r;
  logic [PW_-1:0]        pct1_r, pct2_r, pct3_r;
  logic                  on1_r, on2_r, on3_r, on4_r, on5_r;
  logic                  sub1_r, sub2_r, sub3_r, sub4_r, sub5_r;

  // stage 2
  logic [NW+R1W-1:0]     prod1;
  logic [QW-1:0]         qa2_r;

  // stage 3
  logic [NW:0]           rem1;
  logic [RW-1:0]         r1;
  logic                  ge1;
  logic [QW-1:0]         qf;
  logic [RKW-1:0]        rk3_nxt, rk3_r;
  logic signed [QKW-1:0] qk3_nxt, qk3_r;

  // stage 4
  logic [MW-1:0]         m4_nxt, m4_r, m5_r;
  logic signed [CW-1:0]  qkp4_nxt, qkp4_r, qkp5_r;

  // stage 5
  logic [MW+R2W-1:0]     prod2;
  logic [Q2W-1:0]        q2a5_r;

  // stage 6
  logic [MW:0]           rem2;
  logic                  ge2;
  logic signed [CW-1:0]  corr_sum, corr6_nxt, corr6_r;

  always_comb begin
    brake_on = (brake_pedal_pct != '0);
    pct      = brake_on ? brake_pedal_pct : throttle_pedal_pct;
    eff      = slot_t'(cfg.pedal_limits[15:0]);
    pct_sc   = signed'(TW'({pct, 8'h00}));
    eff_sc   = TW'(eff) * TW'(gkac_pkg::PCT_SCALE);
    slope    = brake_on ? slot_t'(cfg.pedal_slopes[47:32]) : slot_t'(cfg.pedal_slopes[15:0]);
    offset   = brake_on ? slot_t'(cfg.pedal_slopes[63:48]) : slot_t'(cfg.pedal_slopes[31:16]);
    maxv     = brake_on ? slot_t'(cfg.pedal_limits[47:32]) : slot_t'(cfg.pedal_limits[31:16]);
    k_raw    = KW'(slope) * signed'(KW'(pct)) + KW'(offset) * KW'(gkac_pkg::PCT_SCALE);
    k_cap    = KW'(maxv) * KW'(CAP_SCALE);
    k_sel    = (k_raw > k_cap) ? k_cap : k_raw;
    // bias so the floor division runs on a non-negative value
    k_bias   = k_sel + KW'(K_BIAS);
    n1_nxt   = k_bias[NW-1:0];
    on1_nxt  = (pct != '0) && (pct_sc > eff_sc);
  end

  assign prod1 = (NW+R1W)'(n1_r) * (NW+R1W)'(RECIP1);

  always_comb begin
    rem1    = (NW+1)'(n2_r) - (NW+1)'(qa2_r) * (NW+1)'(DIV_C);
    r1      = rem1[RW-1:0];
    ge1     = (r1 >= RW'(DIV_C));
    qf      = qa2_r + QW'(ge1);
    rk3_nxt = ge1 ? RKW'(r1 - RW'(DIV_C)) : RKW'(r1);
    qk3_nxt = signed'(QKW'(qf)) - QKW'(QK_BIAS);
  end

  always_comb begin
    m4_nxt   = ((MW'(rk3_r) * MW'(pct3_r)) << SCALE_SH) + MW'(M_BIAS);
    qkp4_nxt = (CW'(qk3_r) * signed'(CW'(pct3_r))) <<< SCALE_SH;
  end

  assign prod2 = (MW+R2W)'(m4_r) * (MW+R2W)'(RECIP2);

  always_comb begin
    rem2     = (MW+1)'(m5_r) - (MW+1)'(q2a5_r) * (MW+1)'(DIV_C);
    ge2      = (rem2[RW-1:0] >= RW'(DIV_C));
    corr_sum = qkp5_r + signed'(CW'(q2a5_r)) + signed'(CW'(ge2));
    if (!on5_r) begin
      corr6_nxt = '0;
    end else if (sub5_r) begin
      corr6_nxt = -corr_sum;
    end else begin
      corr6_nxt = corr_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      n1_r   <= n1_nxt;
      pct1_r <= pct;
      on1_r  <= on1_nxt;
      sub1_r <= brake_on;
    end
    if (stage_en[1]) begin
      qa2_r  <= prod1[NW+R1W-1:R1_SH];
      n2_r   <= n1_r;
      pct2_r <= pct1_r;
      on2_r  <= on1_r;
      sub2_r <= sub1_r;
    end
    if (stage_en[2]) begin
      qk3_r  <= qk3_nxt;
      rk3_r  <= rk3_nxt;
      pct3_r <= pct2_r;
      on3_r  <= on2_r;
      sub3_r <= sub2_r;
    end
    if (stage_en[3]) begin
      m4_r   <= m4_nxt;
      qkp4_r <= qkp4_nxt;
      on4_r  <= on3_r;
      sub4_r <= sub3_r;
    end
    if (stage_en[4]) begin
      q2a5_r <= prod2[MW+R2W-1:R2_SH];
      m5_r   <= m4_r;
      qkp5_r <= qkp4_r;
      on5_r  <= on4_r;
      sub5_r <= sub4_r;
    end
    if (stage_en[5]) begin
      corr6_r <= corr6_nxt;
    end
  end

  assign corr = corr6_r;

endmodule

>>> design/gkac_out.sv
// Merge of law and pedal correction, rounding to Q7.8 and clipping to the limits.
module gkac_out #(
  parameter int DATA_WIDTH = gkac_pkg::DATA_WIDTH_DEF
) (
  input  logic                                          clk,
  input  logic [gkac_pkg::PIPE_DEPTH-1:0]               stage_en,
  input  gkac_pkg::cfg_regs_t                           cfg,
  input  logic signed [gkac_pkg::acc_w(DATA_WIDTH)-1:0] law_acc,
  input  logic signed [gkac_pkg::CORR_W-1:0]            corr,
  input  logic [1:0]                                    stage_in,
  output logic signed [DATA_WIDTH-1:0]                  accel_command,
  output logic                                          limited,
  output logic [1:0]                                    speed_stage
);

  localparam int AW = gkac_pkg::acc_w(DATA_WIDTH);
  localparam int CW = gkac_pkg::cmd_w(DATA_WIDTH);

  typedef logic signed [gkac_pkg::SLOT_W-1:0] slot_t;

  logic signed [AW-1:0]  sum7;
  logic signed [CW-1:0]  cmd7_r;
  logic [1:0]            st7_r;

  slot_t                 dl_s, al_s, dl_o, al_o;
  logic signed [CW-1:0]  clip;
  logic                  lim_nxt;

  logic signed [DATA_WIDTH-1:0] cmd_r;
  logic                         lim_r;
  logic [1:0]                   st8_r;

  assign sum7 = law_acc + AW'(corr) + AW'(gkac_pkg::RND_HALF);

  always_comb begin
    dl_s = slot_t'(cfg.accel_limits[15:0]);
    al_s = slot_t'(cfg.accel_limits[31:16]);
    if (dl_s >= al_s) begin
      dl_o = al_s;
      al_o = dl_s;
    end else begin
      dl_o = dl_s;
      al_o = al_s;
    end
    if (cmd7_r > CW'(al_o)) begin
      clip    = CW'(al_o);
      lim_nxt = 1'b1;
    end else if (cmd7_r < CW'(dl_o)) begin
      clip    = CW'(dl_o);
      lim_nxt = 1'b1;
    end else begin
      clip    = cmd7_r;
      lim_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      cmd7_r <= sum7[AW-1:gkac_pkg::RND_SH];
      st7_r  <= stage_in;
    end
    if (stage_en[7]) begin
      cmd_r <= clip[DATA_WIDTH-1:0];
      lim_r <= lim_nxt;
      st8_r <= st7_r;
    end
  end

  assign accel_command = cmd_r;
  assign limited       = lim_r;
  assign speed_stage   = st8_r;

endmodule

>>> design/gap_keeping_accel_command_top.sv
// Top level of the gap-keeping acceleration command pipeline with its APB register port.
// An input beat passes an 8-stage pipeline to its result beat. Throughput: one beat per
// cycle while the output is not stalled. Stages 2 and 5 hold the two reciprocal multiplies
// of the pedal correction, stage 2 also the law products, the rest sums, rounding and
// clipping. Each stage holds its item when the next stage is full and stalled, so bubbles
// collapse. Synchronous reset (rst_n low) empties the pipeline, zeroes the cfg registers.
module gap_keeping_accel_command_top #(
  parameter int DATA_WIDTH = gkac_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  gkac_in_if.sink                       in_chan,
  gkac_out_if.source                    out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gkac_pkg::APB_AW-1:0]   paddr,
  input  logic [gkac_pkg::APB_DW-1:0]   pwdata,
  output logic [gkac_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int D  = gkac_pkg::PIPE_DEPTH;
  localparam int AW = gkac_pkg::acc_w(DATA_WIDTH);

  gkac_pkg::cfg_regs_t          cfg;
  logic [D-1:0]                 vld_r, vld_nxt;
  logic [D-1:0]                 adv;
  logic signed [AW-1:0]         law_acc;
  logic signed [gkac_pkg::CORR_W-1:0] corr;
  logic [1:0]                   law_stage;

  gkac_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // advance a stage when it is empty or its successor advances
  always_comb begin
    adv[D-1] = !vld_r[D-1] || out_chan.ready;
    for (int k = D - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt[0] = adv[0] ? in_chan.valid : vld_r[0];
    for (int k = 1; k < D; k++) begin
      vld_nxt[k] = adv[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_chan.ready  = adv[0];
  assign out_chan.valid = vld_r[D-1];

  gkac_law #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_law (
    .clk          (clk),
    .stage_en     (adv),
    .cfg          (cfg),
    .leader_speed (in_chan.leader_speed),
    .own_speed    (in_chan.own_speed),
    .leader_accel (in_chan.leader_accel),
    .gap_distance (in_chan.gap_distance),
    .law_acc      (law_acc),
    .speed_stage  (law_stage)
  );

  gkac_corr u_corr (
    .clk                (clk),
    .stage_en           (adv),
    .cfg                (cfg),
    .brake_pedal_pct    (in_chan.brake_pedal_pct),
    .throttle_pedal_pct (in_chan.throttle_pedal_pct),
    .corr               (corr)
  );

  gkac_out #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_out (
    .clk           (clk),
    .stage_en      (adv),
    .cfg           (cfg),
    .law_acc       (law_acc),
    .corr          (corr),
    .stage_in      (law_stage),
    .accel_command (out_chan.accel_command),
    .limited       (out_chan.limited),
    .speed_stage   (out_chan.speed_stage)
  );

`ifndef SYNTHESIS
  a_bubble_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[0] |-> in_chan.ready)
    else $error("input not ready with an empty first stage");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&vld_r) && !out_chan.ready |-> !in_chan.ready)
    else $error("input beat taken into a full stalled pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready && vld_r[D-2] |=> out_chan.valid && vld_r[D-2])
    else $error("stalled stage lost its item");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (vld_r == '0) && !out_chan.valid)
    else $error("pipeline not empty after reset");
`endif

endmodule
